FILE: src/imu_running_bias_calibration_macros.svh
// Assertion helpers used by the checker file.
`ifndef IMU_RUNNING_BIAS_CALIBRATION_MACROS_SVH
`define IMU_RUNNING_BIAS_CALIBRATION_MACROS_SVH

// Consequent must hold in the same cycle.
`define IBC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Consequent must hold from the next cycle on.
`define IBC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

FILE: src/ibc_pkg.sv
package ibc_pkg;

  localparam int RING_DEPTH_DEF = 256;
  localparam int DEBOUNCE_DEF   = 128;

  localparam int NORM_W = 18;
  localparam logic [NORM_W-1:0] NORM_MAX = '1;
  localparam int DB_W     = 8;
  localparam int C_W      = NORM_W + 4;   // unsaturated corrected accel
  localparam int H_W      = 17;           // corrected gyro
  localparam int SA_W     = 2 * C_W + 1;  // sum of three accel squares
  localparam int G_W      = 2 * H_W + 2;  // sum of three gyro squares
  localparam int SQ_IN_W  = 32;           // raw accel magnitude squared
  localparam int SQ_STEPS = SQ_IN_W / 2;
  localparam int M_W      = SQ_IN_W / 2;

  // 10000*S > (97*4096)^2 and 10000*S < (103*4096)^2, moved onto S.
  localparam logic [63:0] SA_LO = (64'd397312 * 64'd397312) / 64'd10000;
  localparam logic [63:0] SA_HI = (64'd421888 * 64'd421888 - 64'd1) / 64'd10000 + 64'd1;
  localparam logic [63:0] GYRO_LIM = 64'd25600;
  localparam logic [63:0] NORM_ONE = 64'd16777216;

  typedef struct packed {
    logic start;
    logic sqrt_mode;
  } ibc_cmd_t;

  typedef struct packed {
    logic busy;
    logic done;
  } ibc_stat_t;

endpackage

FILE: src/ibc_ram.sv
module ibc_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ibc_divsqrt.sv
module ibc_divsqrt #(
  parameter int DW = 43
) (
  input  logic              clk,
  input  logic              rst,
  input  ibc_pkg::ibc_cmd_t cmd,
  input  logic [DW-1:0]     num,
  input  logic [DW-1:0]     den,
  output ibc_pkg::ibc_stat_t stat,
  output logic [DW-1:0]     result
);
  import ibc_pkg::*;

  localparam int CW = $clog2(DW + 1);

  logic [DW:0]   rem, rem_sh, trial, diff;
  logic [DW-1:0] shreg, quo, dreg;
  logic [CW-1:0] cnt;
  logic          mode, busy, done, ge;

  // Restoring divide takes one quotient bit a cycle; square root one root bit.
  always_comb begin
    if (mode) begin
      rem_sh = {rem[DW-2:0], shreg[DW-1 -: 2]};
      trial  = {quo[DW-2:0], 2'b01};
    end else begin
      rem_sh = {rem[DW-1:0], shreg[DW-1]};
      trial  = {1'b0, dreg};
    end
    ge   = rem_sh >= trial;
    diff = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        busy <= 1'b1;
        mode <= cmd.sqrt_mode;
        rem  <= '0;
        quo  <= '0;
        dreg <= den;
        if (cmd.sqrt_mode) begin
          shreg <= {num[SQ_IN_W-1:0], {(DW - SQ_IN_W){1'b0}}};
          cnt   <= CW'(SQ_STEPS);
        end else begin
          shreg <= num;
          cnt   <= CW'(DW);
        end
      end else if (busy) begin
        rem <= ge ? diff : rem_sh;
        quo <= {quo[DW-2:0], ge};
        if (mode) begin
          shreg <= shreg << 2;
        end else begin
          shreg <= shreg << 1;
        end
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign result    = quo;

endmodule

FILE: src/imu_running_bias_calibration.sv
// channel   | handshake             | payload
// ----------+-----------------------+-----------------------------------------
// input     | in_valid / in_ready   | gyro_x/y/z, accel_x/y/z
// output    | out_valid / out_ready | cal_active, gyro_*_corr, accel_*_corr
// config    | cfg_wr_en             | cfg_wr_data (running mode enable)
//
// During the fill phase each word also runs a magnitude square root and a normalizer
// divide, DW = 35 + clog2(RING_DEPTH) bits wide, on the shared one-bit-per-cycle
// divide / square-root unit; zero accel skips the divide, later words skip both.
// RING_DEPTH is a power of two, so the bias and scale divisions are shifts.
// in_ready is high only in the idle state; a finished word waits in the output register,
// the next word is taken meanwhile and holds in its last step while that register is full.
// Reset is synchronous; unwritten ring slots read as zero by way of the fill count.
module imu_running_bias_calibration #(
  parameter int RING_DEPTH       = ibc_pkg::RING_DEPTH_DEF,
  parameter int DEBOUNCE_SAMPLES = ibc_pkg::DEBOUNCE_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [15:0] gyro_x,
  input  logic signed [15:0] gyro_y,
  input  logic signed [15:0] gyro_z,
  input  logic signed [15:0] accel_x,
  input  logic signed [15:0] accel_y,
  input  logic signed [15:0] accel_z,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               cal_active,
  output logic signed [16:0] gyro_x_corr,
  output logic signed [16:0] gyro_y_corr,
  output logic signed [16:0] gyro_z_corr,
  output logic signed [15:0] accel_x_corr,
  output logic signed [15:0] accel_y_corr,
  output logic signed [15:0] accel_z_corr
);
  import ibc_pkg::*;

  localparam int AW    = $clog2(RING_DEPTH);
  localparam int FC_W  = $clog2(RING_DEPTH + 1);
  localparam int NS_W  = NORM_W + $clog2(RING_DEPTH);
  localparam int SUM_W = 16 + $clog2(RING_DEPTH);
  localparam int DW    = NS_W + 17;
  localparam int MW    = (NS_W + 1 > C_W + 1) ? NS_W + 1 : C_W + 1;
  localparam int PW    = 2 * MW;
  localparam logic [DW-1:0] HALF_ADEN = DW'(RING_DEPTH * 2048);
  localparam logic [DW-1:0] HALF_GDEN = DW'(RING_DEPTH / 2);

  typedef enum logic [3:0] {
    ST_IDLE, ST_CMUL, ST_CDIV, ST_CWAIT, ST_BDIV, ST_BWAIT, ST_SMUL, ST_SACC,
    ST_RMUL, ST_RACC, ST_SQRT, ST_SWAIT, ST_NDIV, ST_NWAIT, ST_UPDATE
  } state_t;

  state_t state;
  logic [2:0] idx;
  logic [1:0] ax, hidx;

  logic signed [15:0]      gin [3];
  logic signed [15:0]      ain [3];
  logic signed [C_W-1:0]   cval [3];
  logic signed [H_W-1:0]   hval [3];
  logic signed [SUM_W-1:0] gsum [3];
  logic signed [15:0]      ring_old [3];
  logic [15:0]             ring_rd [3];

  logic [NS_W-1:0]   norm_sum;
  logic [FC_W-1:0]   fill_count;
  logic [AW-1:0]     wptr;
  logic [DB_W-1:0]   debounce, debounce_next;
  logic              run_en, neg;
  logic [SA_W-1:0]   s_acc;
  logic [G_W-1:0]    g_acc;
  logic [SQ_IN_W-1:0] raw_acc;
  logic [M_W-1:0]    mval;
  logic [NORM_W-1:0] nval;

  logic signed [MW-1:0] mul_a, mul_b;
  logic signed [PW-1:0] prod;
  logic [PW-1:0]        prod_mag;
  logic [SUM_W-1:0]     gsum_mag;

  ibc_cmd_t        dcmd;
  ibc_stat_t       dstat;
  logic [DW-1:0]   dnum, dden, dq, rq;
  logic signed [C_W-1:0] cq;
  logic signed [H_W-1:0] bq;

  logic fill_phase, still, push, active, can_out;

  function automatic logic signed [15:0] sat16(input logic signed [C_W-1:0] v);
    logic signed [15:0] r;
    if (v > C_W'(32767)) begin
      r = 16'sh7fff;
    end else if (v < -C_W'(32768)) begin
      r = -16'sh8000;
    end else begin
      r = 16'(v);
    end
    return r;
  endfunction

  assign ax   = idx[1:0];
  assign hidx = 2'(idx - 3'd3);
  assign fill_phase = fill_count < FC_W'(RING_DEPTH);
  assign in_ready   = (state == ST_IDLE);
  assign can_out    = !out_valid || out_ready;

  // Shared multiplier operands.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      ST_CMUL: begin
        mul_a = MW'(ain[ax]);
        mul_b = MW'({1'b0, norm_sum});
      end
      ST_SMUL: begin
        if (idx < 3'd3) begin
          mul_a = MW'(cval[ax]);
          mul_b = MW'(cval[ax]);
        end else begin
          mul_a = MW'(hval[hidx]);
          mul_b = MW'(hval[hidx]);
        end
      end
      ST_RMUL: begin
        mul_a = MW'(ain[ax]);
        mul_b = MW'(ain[ax]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  assign prod_mag = prod[PW-1] ? PW'(-prod) : PW'(prod);
  assign gsum_mag = gsum[ax][SUM_W-1] ? SUM_W'(-gsum[ax]) : SUM_W'(gsum[ax]);

  // Square-root and normalizer divide requests.
  always_comb begin
    dcmd.start     = 1'b0;
    dcmd.sqrt_mode = 1'b0;
    dnum = '0;
    dden = '0;
    unique case (state)
      ST_SQRT: begin
        dcmd.start     = 1'b1;
        dcmd.sqrt_mode = 1'b1;
        dnum = DW'(raw_acc);
      end
      ST_NDIV: begin
        dcmd.start = 1'b1;
        dnum = DW'(NORM_ONE) + DW'(mval >> 1);
        dden = DW'(mval);
      end
      default: begin
        dnum = '0;
      end
    endcase
  end

  ibc_divsqrt #(.DW(DW)) u_divsqrt (
    .clk    (clk),
    .rst    (rst),
    .cmd    (dcmd),
    .num    (dnum),
    .den    (dden),
    .stat   (dstat),
    .result (dq)
  );

  assign cq = C_W'(rq);
  assign bq = H_W'(rq);

  // Stillness test and debounce.
  always_comb begin
    still = (64'(s_acc) > SA_LO) && (64'(s_acc) < SA_HI) && (64'(g_acc) < GYRO_LIM);
    debounce_next = debounce;
    push = 1'b0;
    if (fill_phase) begin
      push = 1'b1;
    end else if (run_en) begin
      if (!still) begin
        debounce_next = DB_W'(DEBOUNCE_SAMPLES);
      end else if (debounce != '0) begin
        debounce_next = debounce - 1'b1;
      end
      push = (debounce_next == '0);
    end else begin
      debounce_next = DB_W'(DEBOUNCE_SAMPLES);
    end
    active = push;
  end

  for (genvar i = 0; i < 3; i++) begin : g_ring
    ibc_ram #(.WIDTH(16), .DEPTH(RING_DEPTH)) u_ring (
      .clk   (clk),
      .we    (state == ST_UPDATE && can_out && push),
      .waddr (wptr),
      .wdata (gin[i]),
      .raddr (wptr),
      .rdata (ring_rd[i])
    );
    // Slots past the fill count are read as zero while the ring fills.
    assign ring_old[i] = fill_phase ? 16'sd0 : $signed(ring_rd[i]);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      idx        <= '0;
      run_en     <= 1'b0;
      out_valid  <= 1'b0;
      norm_sum   <= '0;
      fill_count <= '0;
      wptr       <= '0;
      debounce   <= '0;
      for (int i = 0; i < 3; i++) begin
        gsum[i] <= '0;
      end
    end else begin
      if (cfg_wr_en) begin
        run_en <= cfg_wr_data;
      end
      if (state == ST_UPDATE && can_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            gin[0] <= gyro_x;
            gin[1] <= gyro_y;
            gin[2] <= gyro_z;
            ain[0] <= accel_x;
            ain[1] <= accel_y;
            ain[2] <= accel_z;
            idx    <= '0;
            state  <= ST_CMUL;
          end
        end
        ST_CMUL: state <= ST_CDIV;
        ST_CDIV: begin
          // round half away: magnitude plus half the divisor, then shift
          neg   <= prod[PW-1];
          rq    <= (DW'(prod_mag) + HALF_ADEN) >> (AW + 12);
          state <= ST_CWAIT;
        end
        ST_CWAIT: begin
          cval[ax] <= neg ? -cq : cq;
          if (idx == 3'd2) begin
            idx   <= '0;
            state <= ST_BDIV;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_CMUL;
          end
        end
        ST_BDIV: begin
          neg   <= gsum[ax][SUM_W-1];
          rq    <= (DW'(gsum_mag) + HALF_GDEN) >> AW;
          state <= ST_BWAIT;
        end
        ST_BWAIT: begin
          hval[ax] <= H_W'(gin[ax]) - (neg ? -bq : bq);
          if (idx == 3'd2) begin
            idx   <= '0;
            s_acc <= '0;
            g_acc <= '0;
            state <= ST_SMUL;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_BDIV;
          end
        end
        ST_SMUL: state <= ST_SACC;
        ST_SACC: begin
          if (idx < 3'd3) begin
            s_acc <= s_acc + SA_W'(prod);
          end else begin
            g_acc <= g_acc + G_W'(prod);
          end
          if (idx == 3'd5) begin
            idx     <= '0;
            raw_acc <= '0;
            // skip the normalizer once the fill phase is over
            state   <= fill_phase ? ST_RMUL : ST_UPDATE;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_SMUL;
          end
        end
        ST_RMUL: state <= ST_RACC;
        ST_RACC: begin
          raw_acc <= raw_acc + SQ_IN_W'(prod);
          if (idx == 3'd2) begin
            state <= ST_SQRT;
          end else begin
            idx   <= idx + 1'b1;
            state <= ST_RMUL;
          end
        end
        ST_SQRT: state <= ST_SWAIT;
        ST_SWAIT: begin
          if (dstat.done) begin
            mval <= M_W'(dq);
            if (M_W'(dq) == '0) begin
              nval  <= NORM_MAX;
              state <= ST_UPDATE;
            end else begin
              state <= ST_NDIV;
            end
          end
        end
        ST_NDIV: state <= ST_NWAIT;
        ST_NWAIT: begin
          if (dstat.done) begin
            nval  <= (dq > DW'(NORM_MAX)) ? NORM_MAX : NORM_W'(dq);
            state <= ST_UPDATE;
          end
        end
        ST_UPDATE: begin
          if (can_out) begin
            debounce <= debounce_next;
            if (push) begin
              for (int i = 0; i < 3; i++) begin
                gsum[i] <= gsum[i] + SUM_W'(gin[i]) - SUM_W'(ring_old[i]);
              end
              wptr <= (wptr == AW'(RING_DEPTH - 1)) ? '0 : wptr + 1'b1;
            end
            if (fill_phase) begin
              norm_sum   <= norm_sum + NS_W'(nval);
              fill_count <= fill_count + 1'b1;
            end
            cal_active  <= active;
            gyro_x_corr <= hval[0];
            gyro_y_corr <= hval[1];
            gyro_z_corr <= hval[2];
            accel_x_corr <= sat16(cval[0]);
            accel_y_corr <= sat16(cval[1]);
            accel_z_corr <= sat16(cval[2]);
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: src/ibc_checker.sv
`include "imu_running_bias_calibration_macros.svh"

module ibc_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_valid,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic               cal_active,
  input logic signed [16:0] gyro_x_corr,
  input logic signed [15:0] accel_x_corr
);

  // A taken word keeps the input side busy.
  `IBC_ASSERT_NEXT(a_busy_after_take, in_valid && in_ready, !in_ready ##1 !in_ready, "ready too soon")

  // A stalled result holds its valid, cal_active and x fields.
  `IBC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(cal_active) && $stable(gyro_x_corr) && $stable(accel_x_corr), "result changed while stalled")

  // Corrected gyro never reaches the most negative code.
  `IBC_ASSERT_NOW(a_gyro_range, out_valid, gyro_x_corr != -17'sd65536, "gyro out of range")

  // A new result only appears while the input side is idle.
  `IBC_ASSERT_NOW(a_rise_idle, $rose(out_valid), in_ready, "result without finishing")

endmodule

bind imu_running_bias_calibration ibc_checker u_ibc_checker (
  .clk          (clk),
  .rst          (rst),
  .in_valid     (in_valid),
  .in_ready     (in_ready),
  .out_valid    (out_valid),
  .out_ready    (out_ready),
  .cal_active   (cal_active),
  .gyro_x_corr  (gyro_x_corr),
  .accel_x_corr (accel_x_corr)
);
